>>> design/mptm_pkg.sv
// ----------------------------------------------------------------------------
// mptm_pkg
// shared types, opcodes and defaults for the multi-pattern token matcher
// ----------------------------------------------------------------------------
package mptm_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int TYPE_BITS_DEF = 8;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_END     = 3'd1;
  localparam logic [2:0] OP_BUILD   = 3'd2;
  localparam logic [2:0] OP_SCAN    = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_value;
    logic [7:0] pattern_type;
  } item_t;

  typedef struct packed {
    logic       status;
    logic       match_found;
    logic [7:0] match_type;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CHK,
    ST_SCAN_CHK,
    ST_SCAN_FAIL,
    ST_SCAN_TYPE,
    ST_B_POP,
    ST_B_POPW,
    ST_B_CRD,
    ST_B_CCHK,
    ST_B_FRD,
    ST_B_FCHK,
    ST_B_WR,
    ST_DONE
  } state_t;

endpackage

>>> design/mptm_stream_if.sv
// ----------------------------------------------------------------------------
// mptm_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface mptm_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> design/mptm_engine.sv
// ----------------------------------------------------------------------------
// mptm_engine
// trie memories and sequencer for insert, end, build, scan and restart items
// ----------------------------------------------------------------------------
module mptm_engine #(
  parameter int MAX_NODES = mptm_pkg::MAX_NODES_DEF,
  parameter int TYPE_BITS = mptm_pkg::TYPE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mptm_pkg::item_t  item,
  output logic             idle,
  output logic             done_valid,
  input  logic             done_ack,
  output mptm_pkg::result_t res
);
  import mptm_pkg::*;

  localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = NB + 8;
  localparam int CHILD_DEPTH = MAX_NODES * 256;

  // memories
  logic [NB:0]          child_mem [CHILD_DEPTH];
  logic [NB-1:0]        fail_mem  [MAX_NODES];
  logic [TYPE_BITS-1:0] type_mem  [MAX_NODES];
  logic [NB-1:0]        queue_mem [MAX_NODES];

  logic [NB:0]          child_rd;
  logic [NB-1:0]        fail_rd;
  logic [TYPE_BITS-1:0] type_rd;
  logic [NB-1:0]        queue_rd;

  logic [AW-1:0]        child_raddr, child_waddr;
  logic [NB:0]          child_wdata;
  logic                 child_we;
  logic [NB-1:0]        fail_raddr, fail_waddr, fail_wdata;
  logic                 fail_we;
  logic [NB-1:0]        type_waddr;
  logic [TYPE_BITS-1:0] type_wdata;
  logic                 type_we;
  logic [NB-1:0]        queue_waddr, queue_wdata;
  logic                 queue_we;

  // control and datapath registers
  state_t               state, state_next;
  logic [2:0]           op;
  logic [7:0]           chr;
  logic [TYPE_BITS-1:0] ptype;
  logic [NB-1:0]        cursor, scan_node, node, fnode, chn, target, land;
  logic [NB:0]          nodes_used, head, tail, guard;
  logic [7:0]           bchr;
  logic [AW-1:0]        clr_addr;
  result_t              res_q;

  logic                 child_valid;
  logic [NB-1:0]        child_idx;
  logic                 room;
  logic [TYPE_BITS+7:0] ptype_wide;
  logic [TYPE_BITS+7:0] type_wide;

  assign child_valid = child_rd[NB];
  assign child_idx   = child_rd[NB-1:0];
  assign room        = nodes_used < (NB+1)'(MAX_NODES);
  assign ptype_wide  = {{TYPE_BITS{1'b0}}, item.pattern_type};
  assign type_wide   = {8'd0, type_rd};

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    child_rd <= child_mem[child_raddr];
  end

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rd <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk) begin
    if (type_we) begin
      type_mem[type_waddr] <= type_wdata;
    end
    type_rd <= type_mem[child_idx];
  end

  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= queue_wdata;
    end
    queue_rd <= queue_mem[head[NB-1:0]];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(CHILD_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (op)
          OP_INSERT: state_next = ST_INS_CHK;
          OP_SCAN:   state_next = ST_SCAN_CHK;
          OP_BUILD:  state_next = ST_B_POP;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_INS_CHK: state_next = ST_DONE;
      ST_SCAN_CHK: begin
        if (child_valid) begin
          state_next = (child_idx != '0) ? ST_SCAN_TYPE : ST_DONE;
        end else if (node == '0 || guard == (NB+1)'(MAX_NODES)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN_FAIL;
        end
      end
      ST_SCAN_FAIL: state_next = ST_SCAN_CHK;
      ST_SCAN_TYPE: state_next = ST_DONE;
      ST_B_POP: state_next = (head < tail) ? ST_B_POPW : ST_DONE;
      ST_B_POPW: state_next = ST_B_CRD;
      ST_B_CRD:  state_next = ST_B_CCHK;
      ST_B_CCHK: begin
        if (!child_valid) begin
          state_next = (bchr == 8'hff) ? ST_B_POP : ST_B_CRD;
        end else if (node == '0) begin
          state_next = ST_B_WR;
        end else begin
          state_next = ST_B_FRD;
        end
      end
      ST_B_FRD: state_next = ST_B_FCHK;
      ST_B_FCHK: begin
        if (child_valid || fnode == '0 || guard == (NB+1)'(MAX_NODES)) begin
          state_next = ST_B_WR;
        end else begin
          state_next = ST_B_FRD;
        end
      end
      ST_B_WR: state_next = (bchr == 8'hff) ? ST_B_POP : ST_B_CRD;
      ST_DONE: begin
        if (done_ack) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    idle        = (state == ST_IDLE);
    done_valid  = (state == ST_DONE);
    child_raddr = (op == OP_SCAN) ? {scan_node, chr} : {cursor, chr};
    child_we    = 1'b0;
    child_waddr = {cursor, chr};
    child_wdata = {1'b1, nodes_used[NB-1:0]};
    fail_raddr  = node;
    fail_we     = 1'b0;
    fail_waddr  = nodes_used[NB-1:0];
    fail_wdata  = '0;
    type_we     = 1'b0;
    type_waddr  = nodes_used[NB-1:0];
    type_wdata  = '0;
    queue_we    = 1'b0;
    queue_waddr = tail[NB-1:0];
    queue_wdata = chn;
    unique case (state)
      ST_CLEAR: begin
        child_we    = 1'b1;
        child_waddr = clr_addr;
        child_wdata = '0;
      end
      ST_DISPATCH: begin
        if (op == OP_END && cursor != '0) begin
          type_we    = 1'b1;
          type_waddr = cursor;
          type_wdata = ptype;
        end
        if (op == OP_BUILD) begin
          queue_we    = 1'b1;
          queue_waddr = '0;
          queue_wdata = '0;
        end
      end
      ST_INS_CHK: begin
        if (!child_valid && room) begin
          child_we = 1'b1;
          fail_we  = 1'b1;
          type_we  = 1'b1;
        end
      end
      ST_SCAN_FAIL: child_raddr = {fail_rd, chr};
      ST_B_CRD:     child_raddr = {node, bchr};
      ST_B_FRD:     child_raddr = {fail_rd, bchr};
      ST_B_FCHK:    fail_raddr  = fnode;
      ST_B_WR: begin
        fail_we    = 1'b1;
        fail_waddr = chn;
        fail_wdata = target;
        queue_we   = tail < (NB+1)'(MAX_NODES);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      nodes_used <= (NB+1)'(1);
      cursor     <= '0;
      scan_node  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_DISPATCH: begin
          if (op == OP_END) cursor <= '0;
          if (op == OP_RESTART) scan_node <= '0;
        end
        ST_INS_CHK: begin
          if (child_valid) begin
            cursor <= child_idx;
          end else if (room) begin
            cursor     <= nodes_used[NB-1:0];
            nodes_used <= nodes_used + (NB+1)'(1);
          end
        end
        ST_SCAN_CHK: begin
          if (!child_valid && (node == '0 || guard == (NB+1)'(MAX_NODES))) begin
            scan_node <= '0;
          end else if (child_valid && child_idx == '0) begin
            scan_node <= '0;
          end
        end
        ST_SCAN_TYPE: scan_node <= (type_rd != '0) ? '0 : land;
        default: ;
      endcase
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op    <= item.opcode;
        chr   <= item.char_value;
        ptype <= ptype_wide[TYPE_BITS-1:0];
      end
      ST_DISPATCH: begin
        res_q <= '0;
        node  <= scan_node;
        guard <= '0;
        head  <= '0;
        tail  <= (NB+1)'(1);
      end
      ST_INS_CHK: begin
        if (!child_valid && !room) res_q.status <= 1'b1;
      end
      ST_SCAN_CHK: begin
        land <= child_idx;
        if (!child_valid) guard <= guard + (NB+1)'(1);
      end
      ST_SCAN_FAIL: node <= fail_rd;
      ST_SCAN_TYPE: begin
        if (type_rd != '0) begin
          res_q.match_found <= 1'b1;
          res_q.match_type  <= type_wide[7:0];
        end
      end
      ST_B_POP: begin
        if (head < tail) head <= head + (NB+1)'(1);
        bchr <= '0;
      end
      ST_B_POPW: node <= queue_rd;
      ST_B_CCHK: begin
        chn    <= child_idx;
        target <= '0;
        guard  <= '0;
        if (!child_valid) bchr <= bchr + 8'd1;
      end
      ST_B_FRD: fnode <= fail_rd;
      ST_B_FCHK: begin
        if (child_valid) target <= child_idx;
        guard <= guard + (NB+1)'(1);
      end
      ST_B_WR: begin
        if (tail < (NB+1)'(MAX_NODES)) tail <= tail + (NB+1)'(1);
        bchr <= bchr + 8'd1;
      end
      default: ;
    endcase
  end

  assign res = res_q;

endmodule

>>> design/multi_pattern_token_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_token_matcher
// multi-pattern byte matcher on a trie with failure links
// ----------------------------------------------------------------------------
// Each item carries an opcode: insert a pattern character, end a pattern with
// its token type, build the failure links, scan one data byte, or restart the
// scan at the root. Every item returns exactly one result transaction. After
// reset the child-link memory is swept clear, one entry per cycle, over all
// MAX_NODES*256 entries; no item is taken during that sweep. A scan byte reads
// the child link of the current node and follows failure links until a child
// is found, the root is reached or a guard limit is hit; every step is a
// registered memory read. A build walks the trie breadth-first: for each node
// popped it checks all 256 character codes and sets each child's failure link
// by walking failure links. The sequencer returns to idle as the result enters
// the output register; a result that waits on the output side holds off the
// next item. A scan landing on a node with a nonzero type reports it and
// returns to the root.
module multi_pattern_token_matcher #(
  parameter int MAX_NODES = mptm_pkg::MAX_NODES_DEF,
  parameter int TYPE_BITS = mptm_pkg::TYPE_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  mptm_stream_if.sink   item,
  mptm_stream_if.source result
);
  import mptm_pkg::*;

  logic    eng_idle;
  logic    eng_done;
  logic    eng_ack;
  result_t eng_res;
  logic    out_valid;
  result_t out_payload;

  // new items only while the sequencer is idle
  assign item.ready = eng_idle;

  // hand a finished result to the output register when it is free
  assign eng_ack = eng_done && (!out_valid || result.ready);

  mptm_engine #(
    .MAX_NODES(MAX_NODES),
    .TYPE_BITS(TYPE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (item.valid && item.ready),
    .item      (item.payload),
    .idle      (eng_idle),
    .done_valid(eng_done),
    .done_ack  (eng_ack),
    .res       (eng_res)
  );

  // output register, holds a result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_ack) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_ack) begin
      out_payload <= eng_res;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_payload;

endmodule
